// File: sv/ctom_pkg.sv
// Shared types and constants for the cluster time-overlap matcher.
package ctom_pkg;

  localparam int unsigned TIME_W    = 13;
  localparam int unsigned PLANE_W   = 2;
  localparam int unsigned SCORE_W   = 17;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned OCOUNT_W  = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 17;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [PLANE_W-1:0] PLANE_COLLECTION = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_TOL    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_OVERLAP = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } ctom_state_e;

endpackage

// File: sv/cluster_time_overlap_match.sv
// Cluster pair time-overlap matcher: hit store, coincidence search and scoring.
//
//  channel   | dir | handshake                   | payload
//  ----------+-----+-----------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid/tready        | tdata, tuser, tlast (one hit request)
//  m_axis    | out | m_axis_tvalid/tready        | tdata (one result per pair)
//  cfg       | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Hits load at one request per cycle while the block is loading.
// After the last request of a pair: a setup state, then a read and a compare state
// per compared hit pair (the collection x induction search through the two memory
// read ports, ending a row early on the first coincidence), then bit-serial division
// and a done state to hand over the result (search skipped if a cluster is empty).
// Reset clears counts, planes, registers and control; hit memories are not cleared.
// A result waiting on m_axis does not stop loading of the next pair; the
// next result waits until the previous one has been taken.
module cluster_time_overlap_match
  import ctom_pkg::*;
#(
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // tdata: plane[1:0], hit_time[14:2], zero[15]
  input  logic [IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: cluster_index[0], no_hit[1]
  input  logic [IN_USER_W-1:0]     s_axis_tuser,
  input  logic                     s_axis_tlast,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: matched[0], compatibility[17:1], induction_plane[19:18],
  //        induction_hits[28:20], collection_hits[37:29], zero[39:38]
  output logic [OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DAT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_HITS);

  // Hit memories
  logic [TIME_W-1:0] mem_a [MAX_HITS];
  logic [TIME_W-1:0] mem_b [MAX_HITS];
  logic [TIME_W-1:0] rdata_a_q, rdata_b_q;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic              we_a, we_b;

  ctom_state_e state_q, state_d;

  logic [CW-1:0]       cnt_a_q, cnt_b_q;
  logic [PLANE_W-1:0]  plane_a_q, plane_b_q;
  logic [TIME_W-1:0]   tol_q;
  logic [SCORE_W-1:0]  minov_q;

  logic                col_b_q;
  logic                ok_q;
  logic [CW-1:0]       ncol_q, nind_q;
  logic [PLANE_W-1:0]  iplane_q;
  logic [CW-1:0]       i_q, j_q;
  logic [CW:0]         rem_q;
  logic [SCORE_W-1:0]  quo_q;
  logic [4:0]          div_cnt_q;

  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // Input fields
  logic               in_idx, in_no_hit, in_acc;
  logic [PLANE_W-1:0] in_plane;
  logic [TIME_W-1:0]  in_time;

  assign in_idx    = s_axis_tuser[0];
  assign in_no_hit = s_axis_tuser[1];
  assign in_plane  = s_axis_tdata[PLANE_W-1:0];
  assign in_time   = s_axis_tdata[PLANE_W +: TIME_W];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign we_a = in_acc && !in_idx && !in_no_hit && (cnt_a_q < MAX_CNT);
  assign we_b = in_acc &&  in_idx && !in_no_hit && (cnt_b_q < MAX_CNT);

  // Pick the collection cluster from the stored planes
  logic col_b_w, found_w;
  assign col_b_w = (plane_b_q == PLANE_COLLECTION);
  assign found_w = col_b_w || (plane_a_q == PLANE_COLLECTION);

  // Compare current collection and induction times
  logic [TIME_W-1:0] col_t, ind_t, diff;
  logic              coinc;
  assign col_t = col_b_q ? rdata_b_q : rdata_a_q;
  assign ind_t = col_b_q ? rdata_a_q : rdata_b_q;
  assign diff  = (ind_t > col_t) ? (ind_t - col_t) : (col_t - ind_t);
  assign coinc = diff < tol_q;

  logic last_i, last_j;
  assign last_i = (i_q == ncol_q - CW'(1));
  assign last_j = (j_q == nind_q - CW'(1));

  // Division step: first step unshifted, then shift in one bit a cycle
  logic [CW:0] div_in, div_sub;
  logic        div_bit;
  assign div_in  = (div_cnt_q == 5'd0) ? rem_q : {rem_q[CW-1:0], 1'b0};
  assign div_bit = (div_in >= {1'b0, ncol_q});
  assign div_sub = div_bit ? (div_in - {1'b0, ncol_q}) : div_in;

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Memory read addresses
  assign raddr_a = col_b_q ? j_q[AW-1:0] : i_q[AW-1:0];
  assign raddr_b = col_b_q ? i_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[cnt_a_q[AW-1:0]] <= in_time;
    rdata_a_q <= mem_a[raddr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b[cnt_b_q[AW-1:0]] <= in_time;
    rdata_b_q <= mem_b[raddr_b];
  end

  // Next state and handshake outputs
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tlast) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (!found_w) begin
          state_d = ST_DONE;
        end else if ((col_b_w ? cnt_b_q : cnt_a_q) == '0) begin
          state_d = ST_DONE;
        end else if ((col_b_w ? cnt_a_q : cnt_b_q) == '0) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if ((coinc || last_j) && last_i) state_d = ST_DIV;
        else                             state_d = ST_READ;
      end
      ST_DIV: begin
        if (div_cnt_q == 5'(FRAC_BITS)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= '0;
      minov_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TIME_TOL:    tol_q   <= cfg_data_i[TIME_W-1:0];
        CFG_MIN_OVERLAP: minov_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pair counts and planes: advance on loads, drop at pair end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      plane_a_q <= '0;
      plane_b_q <= '0;
    end else if (state_q == ST_DONE && out_free) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      plane_a_q <= '0;
      plane_b_q <= '0;
    end else if (in_acc) begin
      if (!in_idx) plane_a_q <= in_plane;
      else         plane_b_q <= in_plane;
      if (we_a) cnt_a_q <= cnt_a_q + CW'(1);
      if (we_b) cnt_b_q <= cnt_b_q + CW'(1);
    end
  end

  // Search and division datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_b_q   <= 1'b0;
      ok_q      <= 1'b0;
      ncol_q    <= '0;
      nind_q    <= '0;
      iplane_q  <= '0;
      i_q       <= '0;
      j_q       <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      case (state_q)
        ST_SETUP: begin
          col_b_q   <= col_b_w;
          ncol_q    <= found_w ? (col_b_w ? cnt_b_q : cnt_a_q) : '0;
          nind_q    <= found_w ? (col_b_w ? cnt_a_q : cnt_b_q) : '0;
          iplane_q  <= found_w ? (col_b_w ? plane_a_q : plane_b_q) : '0;
          ok_q      <= found_w && ((col_b_w ? cnt_b_q : cnt_a_q) != '0);
          i_q       <= '0;
          j_q       <= '0;
          rem_q     <= '0;
          quo_q     <= '0;
          div_cnt_q <= '0;
        end
        ST_CMP: begin
          if (coinc) rem_q <= rem_q + (CW+1)'(1);
          if (coinc || last_j) begin
            j_q <= '0;
            if (!last_i) i_q <= i_q + CW'(1);
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        ST_DIV: begin
          rem_q     <= div_sub;
          quo_q     <= {quo_q[SCORE_W-2:0], div_bit};
          div_cnt_q <= div_cnt_q + 5'd1;
        end
        default: ;
      endcase
    end
  end

  // Result register: hold until taken
  logic out_load;
  assign out_load = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {2'b00,
                     OCOUNT_W'(ncol_q),
                     OCOUNT_W'(nind_q),
                     iplane_q,
                     quo_q,
                     ok_q && (quo_q >= minov_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= MAX_CNT) && (cnt_b_q <= MAX_CNT))
    else $error("hit count beyond capacity");

  a_cmp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ((i_q < ncol_q) && (j_q < nind_q)))
    else $error("search index out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((rem_q <= {1'b0, ncol_q}) && (ncol_q != '0)))
    else $error("division remainder out of range");

  a_pair_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ((cnt_a_q == '0) && (cnt_b_q == '0) && (state_q == ST_LOAD)))
    else $error("pair not cleared after result");

endmodule
